[rtl/record_dc_ac_rms_measure_assert.svh]
// Assertion macros shared by the record mean and RMS measurement RTL
`ifndef RECORD_DC_AC_RMS_MEASURE_ASSERT_SVH
`define RECORD_DC_AC_RMS_MEASURE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define RDM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define RDM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/rdm_pkg.sv]
// Shared constants and types for the record mean and RMS measurement block
package rdm_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int MAX_RECORD  = 1048576;

	localparam int IN_W  = 16;
	localparam int CNT_W = 21;
	localparam int SUM_W = 37;
	localparam int MAG_W = SUM_W - 1;
	localparam int SQR_W = 2 * IN_W;
	localparam int SQ_W  = 52;
	localparam int OUT_W = 24;

	// shift-add multiplier
	localparam int MUL_A_W   = SQ_W;
	localparam int MUL_B_W   = MAG_W;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

	// restoring divider
	localparam int DIV_W     = PROD_W;
	localparam int DEN_W     = 2 * CNT_W;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	// digit-by-digit square root
	localparam int ROOT_W      = OUT_W;
	localparam int RAD_W       = 2 * ROOT_W;
	localparam int SQRT_REM_W  = ROOT_W + 2;
	localparam int SQRT_CNT_W  = $clog2(ROOT_W + 1);

	localparam int VAR_SHIFT = 16;
	localparam int DC_SHIFT  = 8;

	typedef struct packed {
		logic busy;
		logic done;
	} srl_stat_t;

endpackage

[rtl/rdm_if.sv]
// Sample and result channel interfaces

interface rdm_in_if import rdm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [IN_W-1:0]  sample;
	logic                    last;

	modport source (output valid, output sample, output last, input ready);
	modport sink   (input valid, input sample, input last, output ready);
endinterface

interface rdm_out_if import rdm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] dc_mean_q8;
	logic [OUT_W-1:0]        ac_rms_q8;
	logic [OUT_W-1:0]        total_rms_q8;
	logic [CNT_W-1:0]        sample_count;
	logic                    overflow;

	modport source (output valid, output dc_mean_q8, output ac_rms_q8, output total_rms_q8,
		output sample_count, output overflow, input ready);
	modport sink   (input valid, input dc_mean_q8, input ac_rms_q8, input total_rms_q8,
		input sample_count, input overflow, output ready);
endinterface

[rtl/rdm_accum.sv]
// Running sum, sum of squares and sample count over one record
module rdm_accum import rdm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  logic [IN_W-1:0]         sample,
	input  logic                    clr,
	output logic signed [SUM_W-1:0] sum,
	output logic [SQ_W-1:0]         sumsq,
	output logic [CNT_W-1:0]        count,
	output logic                    ovf,
	output logic                    pend
);

	logic signed [IN_W-1:0]  smp_w;
	logic signed [SQR_W-1:0] sq_w;
	logic                    room_w;

	logic                    v_s1;
	logic signed [IN_W-1:0]  smp_s1;
	logic [SQR_W-1:0]        sq_s1;

	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]         sumsq_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    ovf_q;

	// only the low SAMPLE_BITS bits count, as two's complement
	assign smp_w  = IN_W'($signed(sample[SAMPLE_BITS-1:0]));
	assign sq_w   = SQR_W'(smp_w) * SQR_W'(smp_w);
	assign room_w = (cnt_q < CNT_W'(MAX_RECORD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			v_s1  <= 1'b0;
		end else if (clr) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			v_s1  <= 1'b0;
		end else begin
			v_s1 <= take && room_w;
			if (take && room_w) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (take) begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		smp_s1 <= smp_w;
		sq_s1  <= $unsigned(sq_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			sumsq_q <= '0;
		end else if (clr) begin
			sum_q   <= '0;
			sumsq_q <= '0;
		end else if (v_s1) begin
			sum_q   <= sum_q + SUM_W'(smp_s1);
			sumsq_q <= sumsq_q + SQ_W'(sq_s1);
		end
	end

	assign sum   = sum_q;
	assign sumsq = sumsq_q;
	assign count = cnt_q;
	assign ovf   = ovf_q;
	assign pend  = v_s1;

endmodule

[rtl/rdm_mul.sv]
// Shift-add multiplier, one multiplier bit per cycle
module rdm_mul import rdm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [PROD_W-1:0]  prod,
	output srl_stat_t          stat
);

	logic [MUL_A_W-1:0]   a_q;
	logic [PROD_W-1:0]    prod_q;
	logic [MUL_A_W:0]     add_w;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	assign add_w = {1'b0, prod_q[PROD_W-1:MUL_B_W]} + {1'b0, (prod_q[0] ? a_q : '0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= MUL_CNT_W'(MUL_B_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - MUL_CNT_W'(1);
				if (cnt_q == MUL_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// low MUL_B_W bits hold the multiplier, which shifts out as the product shifts in
	always_ff @(posedge clk) begin
		if (go) begin
			a_q    <= a;
			prod_q <= {{MUL_A_W{1'b0}}, b};
		end else if (busy_q) begin
			prod_q <= {add_w, prod_q[MUL_B_W-1:1]};
		end
	end

	assign prod      = prod_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[rtl/rdm_div.sv]
// Restoring divider, one quotient bit per cycle
module rdm_div import rdm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [DIV_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [DIV_W-1:0] quo,
	output logic             rem_nz,
	output srl_stat_t        stat
);

	logic [DIV_W-1:0]     num_q;
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W:0]       trial_w;
	logic [DEN_W+1:0]     diff_w;
	logic                 qbit_w;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	assign trial_w = {rem_q, num_q[DIV_W-1]};
	assign diff_w  = {1'b0, trial_w} - {2'b00, den_q};
	assign qbit_w  = !diff_w[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out at the top, quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_W-2:0], qbit_w};
			rem_q <= qbit_w ? diff_w[DEN_W-1:0] : trial_w[DEN_W-1:0];
		end
	end

	assign quo       = num_q;
	assign rem_nz    = (rem_q != '0);
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[rtl/rdm_sqrt.sv]
// Floor square root, one root bit (two radicand bits) per cycle
module rdm_sqrt import rdm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [RAD_W-1:0]  rad,
	output logic [ROOT_W-1:0] root,
	output srl_stat_t         stat
);

	logic [RAD_W-1:0]        rad_q;
	logic [ROOT_W-1:0]       root_q;
	logic [SQRT_REM_W-1:0]   rem_q;
	logic [SQRT_REM_W+1:0]   trial_w;
	logic [SQRT_REM_W+1:0]   sub_w;
	logic [SQRT_REM_W+2:0]   diff_w;
	logic                    ge_w;
	logic [SQRT_CNT_W-1:0]   cnt_q;
	logic                    busy_q;
	logic                    done_q;

	assign trial_w = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign sub_w   = {2'b00, root_q, 2'b01};
	assign diff_w  = {1'b0, trial_w} - {1'b0, sub_w};
	assign ge_w    = !diff_w[SQRT_REM_W+2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= SQRT_CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - SQRT_CNT_W'(1);
				if (cnt_q == SQRT_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder stays below 2*root+1, so it never outgrows SQRT_REM_W
	always_ff @(posedge clk) begin
		if (go) begin
			rad_q  <= rad;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			root_q <= {root_q[ROOT_W-2:0], ge_w};
			rem_q  <= ge_w ? diff_w[SQRT_REM_W-1:0] : trial_w[SQRT_REM_W-1:0];
		end
	end

	assign root      = root_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[rtl/record_dc_ac_rms_measure.sv]
// Record mean and RMS measurement: accumulator, sequencer and result register
//
//  channel | dir | fields                                               | moves
//  din     | in  | sample, last                                         | one sample per item
//  dout    | out | dc_mean_q8, ac_rms_q8, total_rms_q8, sample_count,   | one result per record
//          |     | overflow                                             |
//
// Samples are taken one per cycle while a record runs; arst_n clears sums, count and control.
// dout.valid rises after the last item once the sequencer has run through the drain state, three
// 36-step multiplies, then an 88-step divide and a 24-step square root for the AC RMS, the same pair
// for the total RMS and an 88-step divide for the mean, each with a launch and a done cycle, then the load.
// din.ready is low from the last item until the load; the result register frees the block
// while dout stalls, and a record that finishes first waits in the done state until it drains.
`include "record_dc_ac_rms_measure_assert.svh"

module record_dc_ac_rms_measure import rdm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	rdm_in_if.sink    din,
	rdm_out_if.source dout
);

	typedef enum logic [10:0] {
		ST_ACCUM    = 11'b000_0000_0001,
		ST_DRAIN    = 11'b000_0000_0010,
		ST_MUL_SSQ  = 11'b000_0000_0100,
		ST_MUL_SUM  = 11'b000_0000_1000,
		ST_MUL_N    = 11'b000_0001_0000,
		ST_DIV_VAR  = 11'b000_0010_0000,
		ST_SQRT_AC  = 11'b000_0100_0000,
		ST_DIV_MS   = 11'b000_1000_0000,
		ST_SQRT_TOT = 11'b001_0000_0000,
		ST_DIV_DC   = 11'b010_0000_0000,
		ST_DONE     = 11'b100_0000_0000
	} seq_state_t;

	seq_state_t state_q, nxt_w;

	logic                    accept_w;
	logic                    load_w;
	logic                    go_q;
	logic                    mul_go_w;
	logic                    div_go_w;
	logic                    sqrt_go_w;

	logic signed [SUM_W-1:0] acc_sum;
	logic [SQ_W-1:0]         acc_sumsq;
	logic [CNT_W-1:0]        acc_cnt;
	logic                    acc_ovf;
	logic                    acc_pend;

	logic                    sum_neg_w;
	logic [SUM_W-1:0]        mag_full_w;
	logic [MAG_W-1:0]        smag_w;

	logic [MUL_A_W-1:0]      mul_a_w;
	logic [MUL_B_W-1:0]      mul_b_w;
	logic [PROD_W-1:0]       mul_prod;
	srl_stat_t               mul_st;

	logic [DIV_W-1:0]        div_num_w;
	logic [DEN_W-1:0]        div_den_w;
	logic [DIV_W-1:0]        div_quo;
	logic                    div_rem_nz;
	srl_stat_t               div_st;

	logic [ROOT_W-1:0]       sqrt_root;
	srl_stat_t               sqrt_st;

	logic [PROD_W-1:0]       p1_q;
	logic [PROD_W-1:0]       dev_q;
	logic [DEN_W-1:0]        nsq_q;
	logic [OUT_W-1:0]        ac_q;
	logic [OUT_W-1:0]        tot_q;
	logic [OUT_W-1:0]        dc_q;
	logic [OUT_W-1:0]        qinc_w;

	logic                    out_valid_q;
	logic [OUT_W-1:0]        dc_out_q;
	logic [OUT_W-1:0]        ac_out_q;
	logic [OUT_W-1:0]        tot_out_q;
	logic [CNT_W-1:0]        cnt_out_q;
	logic                    ovf_out_q;

	assign din.ready = (state_q == ST_ACCUM);
	assign accept_w  = din.valid && din.ready;
	assign load_w    = (state_q == ST_DONE) && (!out_valid_q || dout.ready);

	rdm_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (accept_w),
		.sample (din.sample),
		.clr    (load_w),
		.sum    (acc_sum),
		.sumsq  (acc_sumsq),
		.count  (acc_cnt),
		.ovf    (acc_ovf),
		.pend   (acc_pend)
	);

	assign sum_neg_w  = acc_sum[SUM_W-1];
	assign mag_full_w = sum_neg_w ? (~acc_sum + SUM_W'(1)) : acc_sum;
	assign smag_w     = mag_full_w[MAG_W-1:0];

	// operand selection follows the state the unit is launched in
	always_comb begin
		mul_a_w = '0;
		mul_b_w = '0;
		case (state_q)
			ST_MUL_SSQ: begin
				mul_a_w = acc_sumsq;
				mul_b_w = MUL_B_W'(acc_cnt);
			end
			ST_MUL_SUM: begin
				mul_a_w = MUL_A_W'(smag_w);
				mul_b_w = smag_w;
			end
			ST_MUL_N: begin
				mul_a_w = MUL_A_W'(acc_cnt);
				mul_b_w = MUL_B_W'(acc_cnt);
			end
			default: begin
				mul_a_w = '0;
				mul_b_w = '0;
			end
		endcase
	end

	always_comb begin
		div_num_w = '0;
		div_den_w = '0;
		case (state_q)
			ST_DIV_VAR: begin
				div_num_w = dev_q << VAR_SHIFT;
				div_den_w = nsq_q;
			end
			ST_DIV_MS: begin
				div_num_w = DIV_W'(acc_sumsq) << VAR_SHIFT;
				div_den_w = DEN_W'(acc_cnt);
			end
			ST_DIV_DC: begin
				div_num_w = DIV_W'(smag_w) << DC_SHIFT;
				div_den_w = DEN_W'(acc_cnt);
			end
			default: begin
				div_num_w = '0;
				div_den_w = '0;
			end
		endcase
	end

	// only the unit that belongs to the current state is launched
	assign mul_go_w  = go_q && ((state_q == ST_MUL_SSQ) || (state_q == ST_MUL_SUM)
		|| (state_q == ST_MUL_N));
	assign div_go_w  = go_q && ((state_q == ST_DIV_VAR) || (state_q == ST_DIV_MS)
		|| (state_q == ST_DIV_DC));
	assign sqrt_go_w = go_q && ((state_q == ST_SQRT_AC) || (state_q == ST_SQRT_TOT));

	rdm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go_w),
		.a      (mul_a_w),
		.b      (mul_b_w),
		.prod   (mul_prod),
		.stat   (mul_st)
	);

	rdm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go_w),
		.num    (div_num_w),
		.den    (div_den_w),
		.quo    (div_quo),
		.rem_nz (div_rem_nz),
		.stat   (div_st)
	);

	rdm_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (sqrt_go_w),
		.rad    (div_quo[RAD_W-1:0]),
		.root   (sqrt_root),
		.stat   (sqrt_st)
	);

	always_comb begin
		nxt_w = state_q;
		case (state_q)
			ST_ACCUM:    if (accept_w && din.last) nxt_w = ST_DRAIN;
			ST_DRAIN:    if (!acc_pend) nxt_w = ST_MUL_SSQ;
			ST_MUL_SSQ:  if (mul_st.done) nxt_w = ST_MUL_SUM;
			ST_MUL_SUM:  if (mul_st.done) nxt_w = ST_MUL_N;
			ST_MUL_N:    if (mul_st.done) nxt_w = ST_DIV_VAR;
			ST_DIV_VAR:  if (div_st.done) nxt_w = ST_SQRT_AC;
			ST_SQRT_AC:  if (sqrt_st.done) nxt_w = ST_DIV_MS;
			ST_DIV_MS:   if (div_st.done) nxt_w = ST_SQRT_TOT;
			ST_SQRT_TOT: if (sqrt_st.done) nxt_w = ST_DIV_DC;
			ST_DIV_DC:   if (div_st.done) nxt_w = ST_DONE;
			ST_DONE:     if (load_w) nxt_w = ST_ACCUM;
			default:     nxt_w = ST_ACCUM;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
			go_q    <= 1'b0;
		end else begin
			state_q <= nxt_w;
			// launch the unit on entry to each arithmetic state
			go_q    <= (nxt_w != state_q) && (nxt_w != ST_ACCUM)
				&& (nxt_w != ST_DRAIN) && (nxt_w != ST_DONE);
		end
	end

	// floor for a negative mean: minus the quotient, one more if inexact
	assign qinc_w = div_quo[OUT_W-1:0] + OUT_W'(div_rem_nz);

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL_SSQ && mul_st.done) begin
			p1_q <= mul_prod;
		end
		if (state_q == ST_MUL_SUM && mul_st.done) begin
			dev_q <= p1_q - mul_prod;
		end
		if (state_q == ST_MUL_N && mul_st.done) begin
			nsq_q <= mul_prod[DEN_W-1:0];
		end
		if (state_q == ST_SQRT_AC && sqrt_st.done) begin
			ac_q <= sqrt_root;
		end
		if (state_q == ST_SQRT_TOT && sqrt_st.done) begin
			tot_q <= sqrt_root;
		end
		if (state_q == ST_DIV_DC && div_st.done) begin
			dc_q <= sum_neg_w ? (~qinc_w + OUT_W'(1)) : div_quo[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_w) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_w) begin
			dc_out_q  <= dc_q;
			ac_out_q  <= ac_q;
			tot_out_q <= tot_q;
			cnt_out_q <= acc_cnt;
			ovf_out_q <= acc_ovf;
		end
	end

	assign dout.valid        = out_valid_q;
	assign dout.dc_mean_q8   = $signed(dc_out_q);
	assign dout.ac_rms_q8    = ac_out_q;
	assign dout.total_rms_q8 = tot_out_q;
	assign dout.sample_count = cnt_out_q;
	assign dout.overflow     = ovf_out_q;

	`RDM_ASSERT_NXT(a_last_drains, accept_w && din.last, state_q == ST_DRAIN,
		"last item did not end the record")
	`RDM_ASSERT_IMP(a_one_unit, 1'b1, $onehot0({mul_st.busy, div_st.busy, sqrt_st.busy}),
		"more than one arithmetic unit busy")
	`RDM_ASSERT_IMP(a_dev_pos, state_q == ST_MUL_N, !dev_q[PROD_W-1],
		"negative deviation sum")
	`RDM_ASSERT_IMP(a_ac_le_tot, load_w, ac_q <= tot_q,
		"AC RMS above total RMS")
	`RDM_ASSERT_IMP(a_valid_src, $rose(out_valid_q), $past(state_q == ST_DONE),
		"result shown without finished computation")

endmodule

[tb/sv/record_dc_ac_rms_measure_test.sv]
// Self-checking testbench for the record mean and RMS measurement block
`timescale 1ns / 1ps

module record_dc_ac_rms_measure_test import rdm_pkg::*; ();

	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 500;
	localparam int RANDOM_ITEMS = 1000;

	typedef enum {WAVE_FULL, WAVE_SMALL, WAVE_EXTREME, WAVE_OFFSET} wave_style_t;

	typedef struct {
		logic signed [OUT_W-1:0] dc_mean;
		logic [OUT_W-1:0]        ac_rms;
		logic [OUT_W-1:0]        total_rms;
		logic [CNT_W-1:0]        count;
		logic                    overflow;
	} record_stats_t;

	logic clk;
	logic arst_n;

	rdm_in_if  din_ch();
	rdm_out_if dout_ch();

	record_dc_ac_rms_measure dut (
		.clk(clk),
		.arst_n(arst_n),
		.din(din_ch),
		.dout(dout_ch)
	);

	// model of the accumulator state
	longint      acc_sum;
	logic [63:0] acc_sq;
	int unsigned acc_n;
	bit          acc_ovf;

	record_stats_t record_stats[$];
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int items_sent;
	bit no_idle;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [63:0] floor_root(input logic [63:0] x);
		logic [63:0]  root;
		logic [63:0]  trial;
		logic [127:0] trial_sq;
		root = '0;
		for (int i = 31; i >= 0; i--) begin
			trial = root | (64'd1 << i);
			trial_sq = 128'(trial) * 128'(trial);
			if (trial_sq <= 128'(x))
				root = trial;
		end
		return root;
	endfunction

	// fold one accepted sample into the sums; on the last one, queue the record's figures
	function automatic void fold_sample(input logic signed [IN_W-1:0] s, input logic is_last);
		longint        sv;
		longint        scaled;
		longint        quot;
		longint        n_s;
		longint        mag;
		logic [127:0]  n_w;
		logic [127:0]  dev;
		logic [127:0]  var_q;
		logic [127:0]  mean_sq;
		logic [63:0]   root;
		record_stats_t res;
		sv = longint'(s);
		if (acc_n < MAX_RECORD) begin
			acc_sum += sv;
			acc_sq += 64'(sv * sv);
			acc_n++;
		end else begin
			acc_ovf = 1'b1;
		end
		if (!is_last)
			return;

		n_s = longint'(acc_n);
		scaled = acc_sum * 256;
		quot = scaled / n_s;
		if (scaled % n_s < 0)
			quot -= 1;
		res.dc_mean = quot[OUT_W-1:0];

		mag = (acc_sum < 0) ? -acc_sum : acc_sum;
		n_w = 128'(acc_n);
		dev = n_w * 128'(acc_sq) - 128'(mag) * 128'(mag);
		var_q = (dev << 16) / (n_w * n_w);
		root = floor_root(var_q[63:0]);
		res.ac_rms = root[OUT_W-1:0];

		mean_sq = (128'(acc_sq) << 16) / n_w;
		root = floor_root(mean_sq[63:0]);
		res.total_rms = root[OUT_W-1:0];

		res.count = acc_n[CNT_W-1:0];
		res.overflow = acc_ovf;
		record_stats.push_back(res);

		acc_sum = 0;
		acc_sq = '0;
		acc_n = 0;
		acc_ovf = 1'b0;
	endfunction

	function automatic int draw_idle();
		return no_idle ? 0 : $urandom_range(0, 4);
	endfunction

	function automatic logic signed [IN_W-1:0] make_sample(input wave_style_t style);
		logic signed [IN_W-1:0] s;
		case (style)
			WAVE_FULL: begin
				s = IN_W'($urandom);
			end
			WAVE_SMALL: begin
				s = IN_W'($signed($urandom_range(0, 64)) - 32);
			end
			WAVE_EXTREME: begin
				case ($urandom_range(0, 3))
					0: s = 16'sh7FFF;
					1: s = 16'sh8000;
					2: s = 16'sh0000;
					default: s = 16'shFFFF;
				endcase
			end
			default: begin
				s = IN_W'(20000 + $signed($urandom_range(0, 2000)) - 1000);
				if ($urandom_range(0, 1))
					s = -s;
			end
		endcase
		return s;
	endfunction

	// one sample item; valid stays high between items when no gap is drawn
	task automatic send_sample(input logic signed [IN_W-1:0] s, input logic is_last);
		int gap;
		gap = draw_idle();
		if (gap > 0) begin
			din_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_ch.valid <= 1'b1;
		din_ch.sample <= s;
		din_ch.last <= is_last;
		@(posedge clk);
		while (!din_ch.ready) @(posedge clk);
		fold_sample(s, is_last);
		items_sent++;
	endtask

	task automatic send_record(input int len, input wave_style_t style);
		for (int i = 0; i < len; i++)
			send_sample(make_sample(style), i == len - 1);
	endtask

	task automatic wait_results();
		din_ch.valid <= 1'b0;
		@(posedge clk);
		while (record_stats.size() != 0) @(posedge clk);
	endtask

	task automatic test_extremes();
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sh0000, 1'b1);
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sd1, 1'b1);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh7FFF, 1'b1);
		for (int i = 0; i < 3; i++)
			send_sample(16'sh8000, i == 2);
		// negative mean with a remainder, so floor differs from truncation
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd0, 1'b1);
		send_sample(16'sd1, 1'b0);
		send_sample(16'sd2, 1'b0);
		send_sample(16'sd3, 1'b0);
		send_sample(16'sd4, 1'b1);
		send_sample(16'sh5555, 1'b0);
		send_sample(16'shAAAA, 1'b1);
	endtask

	task automatic test_back_to_back();
		no_idle = 1'b1;
		for (int r = 0; r < 4; r++)
			send_record($urandom_range(1, 5), WAVE_FULL);
		no_idle = 1'b0;
		wait_results();
	endtask

	task automatic test_random_records();
		int          target;
		int          len;
		wave_style_t style;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			no_idle = ($urandom_range(0, 4) == 0);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
			style = wave_style_t'($urandom_range(0, 3));
			send_record(len, style);
			if ($urandom_range(0, 15) == 0)
				wait_results();
		end
		no_idle = 1'b0;
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		record_stats_t want;
		if (arst_n && dout_ch.valid && dout_ch.ready) begin
			if (record_stats.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual dc %0d count %0d",
					$time, dout_ch.dc_mean_q8, dout_ch.sample_count);
				mismatch_count++;
			end else begin
				want = record_stats.pop_front();
				check_field("dc_mean_q8", want.dc_mean, dout_ch.dc_mean_q8);
				check_field("ac_rms_q8", want.ac_rms, dout_ch.ac_rms_q8);
				check_field("total_rms_q8", want.total_rms, dout_ch.total_rms_q8);
				check_field("sample_count", want.count, dout_ch.sample_count);
				check_field("overflow", want.overflow, dout_ch.overflow);
			end
		end
	end

	always @(posedge clk) begin
		if ((din_ch.valid && din_ch.ready) || (dout_ch.valid && dout_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side: a random stall before each item
	initial begin
		int stall;
		dout_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = draw_idle();
			if (stall > 0) begin
				dout_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dout_ch.ready <= 1'b1;
			@(posedge clk);
			while (!dout_ch.valid) @(posedge clk);
		end
	end

	initial begin
		arst_n <= 1'b0;
		din_ch.valid <= 1'b0;
		din_ch.sample <= '0;
		din_ch.last <= 1'b0;
		acc_sum = 0;
		acc_sq = '0;
		acc_n = 0;
		acc_ovf = 1'b0;
		items_sent = 0;
		no_idle = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_back_to_back();
		test_random_records();

		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/rdm_pkg.sv
rtl/rdm_if.sv
rtl/rdm_accum.sv
rtl/rdm_mul.sv
rtl/rdm_div.sv
rtl/rdm_sqrt.sv
rtl/record_dc_ac_rms_measure.sv
tb/sv/record_dc_ac_rms_measure_test.sv
